[design/three_class_nearest_classifier_macros.svh]
// Assertion helpers for the three-class nearest classifier.
// Each macro expects clk and rst_n in scope.
`ifndef THREE_CLASS_NEAREST_CLASSIFIER_MACROS_SVH
`define THREE_CLASS_NEAREST_CLASSIFIER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TCNC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define TCNC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tcnc_pkg.sv]
// ----------------------------------------------------------------------------
// tcnc_pkg
// Types, sizes and codes shared by the three-class nearest classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tcnc_pkg;

  // Table and number formats
  localparam int TABLE_DEPTH   = 64;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int COORD_BITS    = 12;
  localparam int FRACTION_BITS = 8;
  localparam int NUM_CLASSES   = 3;
  localparam int DIST_CAP      = 1000;
  localparam int DIST_W        = $clog2(DIST_CAP + 1);

  // Derived datapath widths
  localparam int SUM_W   = COORD_BITS + ADDR_W + 1;
  localparam int CEN_W   = COORD_BITS + FRACTION_BITS + 1;
  localparam int CDIFF_W = CEN_W + 1;
  localparam int CSQ_W   = 2 * CDIFF_W - 1;
  localparam int CD2_W   = CSQ_W + 1;
  localparam int NDIFF_W = COORD_BITS + 1;
  localparam int NSQ_W   = 2 * NDIFF_W - 1;
  localparam int ND2_W   = NSQ_W + 1;
  localparam int RAD_W   = CD2_W - 2 * FRACTION_BITS;
  localparam int DVD_W   = SUM_W + FRACTION_BITS;
  localparam int REM_W   = CNT_W + 1;
  localparam int STEP_W  = $clog2(DVD_W);
  localparam int BIT_W   = $clog2(DIST_W);

  typedef logic        [CNT_W-1:0]      cnt_t;
  typedef logic        [ADDR_W-1:0]     addr_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [CEN_W-1:0]      cen_t;
  typedef logic signed [CDIFF_W-1:0]    cdiff_t;
  typedef logic        [CSQ_W-1:0]      csq_t;
  typedef logic        [CD2_W-1:0]      cd2_t;
  typedef logic signed [NDIFF_W-1:0]    ndiff_t;
  typedef logic        [NSQ_W-1:0]      nsq_t;
  typedef logic        [ND2_W-1:0]      nd2_t;
  typedef logic        [RAD_W-1:0]      rad_t;
  typedef logic        [DVD_W-1:0]      dvd_t;
  typedef logic        [REM_W-1:0]      rem_t;
  typedef logic        [STEP_W-1:0]     step_t;
  typedef logic        [BIT_W-1:0]      bitidx_t;
  typedef logic        [DIST_W-1:0]     dist_t;
  typedef logic        [1:0]            cls_t;
  typedef logic        [2:0]            sel_t;

  // Class codes
  localparam cls_t CLS_RED       = 2'd0;
  localparam cls_t CLS_GREEN     = 2'd2;
  localparam cls_t LABEL_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_FREEZE   = 2'd1,
    MODE_CENTROID = 2'd2,
    MODE_NEIGHBOR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LABEL = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_CLASS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_CMUL,
    S_CACC,
    S_SCAN,
    S_SQRT,
    S_FIN
  } state_t;

  typedef struct packed {
    mode_t  mode;
    coord_t x;
    coord_t y;
    cls_t   label;
  } in_item_t;

  typedef struct packed {
    status_t status;
    cls_t    class_out;
    dist_t   nearest_distance;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    coord_t x;
    coord_t y;
    cls_t   cls;
  } point_t;

endpackage

`default_nettype wire

[design/three_class_nearest_classifier.sv]
// ----------------------------------------------------------------------------
// three_class_nearest_classifier
// Labelled point table with per-class sums; loads, freezes centroids and
// classifies by nearest centroid or nearest stored neighbour.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. Each item gives
//   exactly one result, shown on out_item for one cycle with out_valid high;
//   the receiver must take it then, it cannot stall the block.
//   What each mode does from accept to out_valid:
//     load            stores a point with a known label unless the table is full
//     freeze          six quotients (one restoring divider step per cycle;
//                     an empty class is cleared without a divide)
//     by centroid     three squared distances, then the bit-serial square
//                     root, one root bit per cycle
//     by neighbour    one table read per cycle from the point memory, then
//                     one bit-serial root per class that has a stored point
//   A load never raises busy; for the other modes busy stays high from accept
//   until the result cycle. A new item may be taken in the cycle its
//   predecessor's result is shown.
//   Reset empties the table, clears sums, counts and centroids. The point
//   memory itself is not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_class_nearest_classifier_macros.svh"

module three_class_nearest_classifier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tcnc_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                out_valid,
  output tcnc_pkg::out_item_t out_item
);

  // Control and class state
  tcnc_pkg::state_t    state_r, state_nxt;
  tcnc_pkg::in_item_t  item_r, item_nxt;
  tcnc_pkg::cnt_t      cnt_r, cnt_nxt;
  tcnc_pkg::sum_t      sum_x_r [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::sum_t      sum_x_nxt [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::sum_t      sum_y_r [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::sum_t      sum_y_nxt [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::cnt_t      mcnt_r [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::cnt_t      mcnt_nxt [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::cen_t      cen_x_r [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::cen_t      cen_x_nxt [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::cen_t      cen_y_r [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::cen_t      cen_y_nxt [tcnc_pkg::NUM_CLASSES];
  logic [tcnc_pkg::NUM_CLASSES-1:0] cen_v_r, cen_v_nxt;

  // Divider
  tcnc_pkg::sel_t      sel_r, sel_nxt;
  tcnc_pkg::step_t     step_r, step_nxt;
  tcnc_pkg::dvd_t      dvd_r, dvd_nxt;
  tcnc_pkg::dvd_t      quo_r, quo_nxt;
  tcnc_pkg::rem_t      rem_r, rem_nxt;
  logic                neg_r, neg_nxt;

  // Distance search
  tcnc_pkg::cls_t      cls_r, cls_nxt;
  tcnc_pkg::csq_t      sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  tcnc_pkg::cd2_t      best_r, best_nxt;
  tcnc_pkg::cls_t      win_r, win_nxt;
  logic                found_r, found_nxt;
  tcnc_pkg::dist_t     dist_r, dist_nxt;
  tcnc_pkg::cnt_t      idx_r, idx_nxt;
  logic                s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  tcnc_pkg::cls_t      s2_cls_r, s2_cls_nxt;
  tcnc_pkg::nsq_t      nsqx_r, nsqx_nxt, nsqy_r, nsqy_nxt;
  tcnc_pkg::nd2_t      nn_best_r [tcnc_pkg::NUM_CLASSES];
  tcnc_pkg::nd2_t      nn_best_nxt [tcnc_pkg::NUM_CLASSES];
  logic [tcnc_pkg::NUM_CLASSES-1:0] nn_has_r, nn_has_nxt;
  tcnc_pkg::dist_t     root_r, root_nxt;
  tcnc_pkg::bitidx_t   bit_r, bit_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  tcnc_pkg::out_item_t out_r, out_nxt;

  // Point memory
  tcnc_pkg::point_t    point_mem [tcnc_pkg::TABLE_DEPTH];
  tcnc_pkg::point_t    rd_q_r;
  logic                rd_en;
  logic                wr_en;
  tcnc_pkg::point_t    wr_data;

  assign busy      = (state_r != tcnc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      point_mem[cnt_r[tcnc_pkg::ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= point_mem[idx_r[tcnc_pkg::ADDR_W-1:0]];
    end
  end

  // Next state and datapath
  always_comb begin
    logic                 commit_en;
    tcnc_pkg::cls_t       commit_cls;
    tcnc_pkg::coord_t     commit_x, commit_y;
    logic                 full;
    tcnc_pkg::cls_t       dcls;
    tcnc_pkg::sum_t       dsum, dmag;
    tcnc_pkg::rem_t       rem_sh, dnum;
    logic                 ge;
    tcnc_pkg::dvd_t       q_fin;
    tcnc_pkg::cen_t       q_sgn;
    tcnc_pkg::cdiff_t     sx, sy, dx, dy;
    logic signed [2*tcnc_pkg::CDIFF_W-1:0] pxx, pyy;
    tcnc_pkg::cd2_t       cd2;
    tcnc_pkg::ndiff_t     nx, ny;
    logic signed [2*tcnc_pkg::NDIFF_W-1:0] pnx, pny;
    tcnc_pkg::nd2_t       nd2;
    tcnc_pkg::rad_t       rad;
    tcnc_pkg::dist_t      trial, root_new;
    logic [2*tcnc_pkg::DIST_W-1:0] tsq;
    logic                 class_end;
    logic                 last_cls;

    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    mcnt_nxt      = mcnt_r;
    cen_x_nxt     = cen_x_r;
    cen_y_nxt     = cen_y_r;
    cen_v_nxt     = cen_v_r;
    sel_nxt       = sel_r;
    step_nxt      = step_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    cls_nxt       = cls_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    best_nxt      = best_r;
    win_nxt       = win_r;
    found_nxt     = found_r;
    dist_nxt      = dist_r;
    idx_nxt       = idx_r;
    s2_cls_nxt    = s2_cls_r;
    nsqx_nxt      = nsqx_r;
    nsqy_nxt      = nsqy_r;
    nn_best_nxt   = nn_best_r;
    nn_has_nxt    = nn_has_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    commit_en     = 1'b0;
    commit_cls    = win_r;
    commit_x      = item_r.x;
    commit_y      = item_r.y;
    class_end     = 1'b0;
    last_cls      = (cls_r == tcnc_pkg::CLS_GREEN);
    full          = (cnt_r >= tcnc_pkg::cnt_t'(tcnc_pkg::TABLE_DEPTH));

    // Divider step (restoring, one quotient bit a cycle)
    dcls   = sel_r[2:1];
    dsum   = sel_r[0] ? sum_y_r[dcls] : sum_x_r[dcls];
    dmag   = dsum[tcnc_pkg::SUM_W-1] ? -dsum : dsum;
    dnum   = tcnc_pkg::rem_t'(mcnt_r[dcls]);
    rem_sh = {rem_r[tcnc_pkg::REM_W-2:0], dvd_r[tcnc_pkg::DVD_W-1]};
    ge     = (rem_sh >= dnum);
    q_fin  = {quo_r[tcnc_pkg::DVD_W-2:0], ge};
    q_sgn  = tcnc_pkg::cen_t'(neg_r ? -q_fin : q_fin);

    // Centroid distance operands
    sx  = tcnc_pkg::cdiff_t'(item_r.x) <<< tcnc_pkg::FRACTION_BITS;
    sy  = tcnc_pkg::cdiff_t'(item_r.y) <<< tcnc_pkg::FRACTION_BITS;
    dx  = sx - tcnc_pkg::cdiff_t'(cen_x_r[cls_r]);
    dy  = sy - tcnc_pkg::cdiff_t'(cen_y_r[cls_r]);
    pxx = dx * dx;
    pyy = dy * dy;
    cd2 = tcnc_pkg::cd2_t'(sqx_r) + tcnc_pkg::cd2_t'(sqy_r);

    // Neighbour distance operands
    nx  = tcnc_pkg::ndiff_t'(rd_q_r.x) - tcnc_pkg::ndiff_t'(item_r.x);
    ny  = tcnc_pkg::ndiff_t'(rd_q_r.y) - tcnc_pkg::ndiff_t'(item_r.y);
    pnx = nx * nx;
    pny = ny * ny;
    nd2 = tcnc_pkg::nd2_t'(nsqx_r) + tcnc_pkg::nd2_t'(nsqy_r);

    // Square root step: greedy root bit, bounded by the cap
    rad = (item_r.mode == tcnc_pkg::MODE_CENTROID) ?
          best_r[tcnc_pkg::CD2_W-1:2*tcnc_pkg::FRACTION_BITS] :
          tcnc_pkg::rad_t'(nn_best_r[cls_r]);
    trial    = root_r | (tcnc_pkg::dist_t'(1) << bit_r);
    tsq      = trial * trial;
    root_new = ((trial <= tcnc_pkg::dist_t'(tcnc_pkg::DIST_CAP)) &&
                (tcnc_pkg::rad_t'(tsq) <= rad)) ? trial : root_r;

    // Scan pipeline: read, square, keep per-class minimum
    rd_en      = (state_r == tcnc_pkg::S_SCAN) && (idx_r < cnt_r);
    s1_v_nxt   = rd_en;
    s2_v_nxt   = s1_v_r;
    if (s1_v_r) begin
      nsqx_nxt   = pnx[tcnc_pkg::NSQ_W-1:0];
      nsqy_nxt   = pny[tcnc_pkg::NSQ_W-1:0];
      s2_cls_nxt = rd_q_r.cls;
    end
    if (s2_v_r) begin
      if (!nn_has_r[s2_cls_r] || (nd2 < nn_best_r[s2_cls_r])) begin
        nn_best_nxt[s2_cls_r] = nd2;
      end
      nn_has_nxt[s2_cls_r] = 1'b1;
    end

    unique case (state_r)
      tcnc_pkg::S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          unique case (in_item.mode)
            tcnc_pkg::MODE_LOAD: begin
              out_valid_nxt = 1'b1;
              if (in_item.label == tcnc_pkg::LABEL_UNKNOWN) begin
                out_nxt = '{tcnc_pkg::ST_BAD_LABEL, tcnc_pkg::CLS_RED, '0};
              end else begin
                commit_en  = 1'b1;
                commit_cls = in_item.label;
                commit_x   = in_item.x;
                commit_y   = in_item.y;
                out_nxt    = '{full ? tcnc_pkg::ST_FULL : tcnc_pkg::ST_OK,
                               in_item.label, '0};
              end
            end
            tcnc_pkg::MODE_FREEZE: begin
              sel_nxt   = '0;
              state_nxt = tcnc_pkg::S_DIV_LOAD;
            end
            tcnc_pkg::MODE_CENTROID: begin
              cls_nxt   = tcnc_pkg::CLS_RED;
              found_nxt = 1'b0;
              state_nxt = tcnc_pkg::S_CMUL;
            end
            tcnc_pkg::MODE_NEIGHBOR: begin
              idx_nxt    = '0;
              nn_has_nxt = '0;
              found_nxt  = 1'b0;
              state_nxt  = tcnc_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end

      // Freeze: set up one quotient, or clear an empty class at once
      tcnc_pkg::S_DIV_LOAD: begin
        if (mcnt_r[dcls] == '0) begin
          cen_v_nxt[dcls] = 1'b0;
          if (sel_r[0]) cen_y_nxt[dcls] = '0;
          else          cen_x_nxt[dcls] = '0;
          class_end = 1'b1;
        end else begin
          dvd_nxt   = tcnc_pkg::dvd_t'(unsigned'(dmag)) << tcnc_pkg::FRACTION_BITS;
          neg_nxt   = dsum[tcnc_pkg::SUM_W-1];
          rem_nxt   = '0;
          quo_nxt   = '0;
          step_nxt  = '0;
          state_nxt = tcnc_pkg::S_DIV_RUN;
        end
      end

      tcnc_pkg::S_DIV_RUN: begin
        rem_nxt  = ge ? (rem_sh - dnum) : rem_sh;
        quo_nxt  = q_fin;
        dvd_nxt  = dvd_r << 1;
        step_nxt = step_r + 1'b1;
        if (step_r == tcnc_pkg::step_t'(tcnc_pkg::DVD_W - 1)) begin
          cen_v_nxt[dcls] = 1'b1;
          if (sel_r[0]) cen_y_nxt[dcls] = q_sgn;
          else          cen_x_nxt[dcls] = q_sgn;
          class_end = 1'b1;
        end
      end

      // Centroid: square both axes, then compare
      tcnc_pkg::S_CMUL: begin
        sqx_nxt   = pxx[tcnc_pkg::CSQ_W-1:0];
        sqy_nxt   = pyy[tcnc_pkg::CSQ_W-1:0];
        state_nxt = tcnc_pkg::S_CACC;
      end

      tcnc_pkg::S_CACC: begin
        if (cen_v_r[cls_r] && (!found_r || (cd2 < best_r))) begin
          best_nxt  = cd2;
          win_nxt   = cls_r;
          found_nxt = 1'b1;
        end
        if (last_cls) begin
          root_nxt  = '0;
          bit_nxt   = tcnc_pkg::bitidx_t'(tcnc_pkg::DIST_W - 1);
          state_nxt = (found_r || cen_v_r[cls_r]) ? tcnc_pkg::S_SQRT : tcnc_pkg::S_FIN;
        end else begin
          cls_nxt   = cls_r + 1'b1;
          state_nxt = tcnc_pkg::S_CMUL;
        end
      end

      // Neighbour: stream the table
      tcnc_pkg::S_SCAN: begin
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!s1_v_r && !s2_v_r) begin
          cls_nxt   = tcnc_pkg::CLS_RED;
          root_nxt  = '0;
          bit_nxt   = tcnc_pkg::bitidx_t'(tcnc_pkg::DIST_W - 1);
          state_nxt = tcnc_pkg::S_SQRT;
        end
      end

      tcnc_pkg::S_SQRT: begin
        if (item_r.mode == tcnc_pkg::MODE_CENTROID) begin
          root_nxt = root_new;
          bit_nxt  = bit_r - 1'b1;
          if (bit_r == '0) begin
            dist_nxt  = root_new;
            state_nxt = tcnc_pkg::S_FIN;
          end
        end else begin
          if (!nn_has_r[cls_r]) begin
            class_end = 1'b1;
          end else begin
            root_nxt = root_new;
            bit_nxt  = bit_r - 1'b1;
            if (bit_r == '0) begin
              class_end = 1'b1;
              if (!found_r || (root_new < dist_r)) begin
                dist_nxt  = root_new;
                win_nxt   = cls_r;
                found_nxt = 1'b1;
              end
            end
          end
          if (class_end) begin
            root_nxt = '0;
            bit_nxt  = tcnc_pkg::bitidx_t'(tcnc_pkg::DIST_W - 1);
            if (last_cls) state_nxt = tcnc_pkg::S_FIN;
            else          cls_nxt   = cls_r + 1'b1;
          end
        end
      end

      // Classification result and point store
      tcnc_pkg::S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = tcnc_pkg::S_IDLE;
        if (!found_r) begin
          out_nxt = '{tcnc_pkg::ST_NO_CLASS, tcnc_pkg::CLS_RED, '0};
        end else begin
          commit_en = 1'b1;
          out_nxt   = '{full ? tcnc_pkg::ST_FULL : tcnc_pkg::ST_OK, win_r, dist_r};
        end
      end

      default: state_nxt = tcnc_pkg::S_IDLE;
    endcase

    // Freeze sequencing over the six quotients
    if ((state_r == tcnc_pkg::S_DIV_LOAD || state_r == tcnc_pkg::S_DIV_RUN) && class_end) begin
      if (sel_r == tcnc_pkg::sel_t'(2 * tcnc_pkg::NUM_CLASSES - 1)) begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{((mcnt_r[0] | mcnt_r[1] | mcnt_r[2]) != '0) ?
                          tcnc_pkg::ST_OK : tcnc_pkg::ST_NO_CLASS,
                          tcnc_pkg::CLS_RED, '0};
        state_nxt     = tcnc_pkg::S_IDLE;
      end else begin
        sel_nxt   = sel_r + 1'b1;
        state_nxt = tcnc_pkg::S_DIV_LOAD;
      end
    end

    // Store a point and add it to its class
    wr_en   = commit_en && !full;
    wr_data = '{commit_x, commit_y, commit_cls};
    if (wr_en) begin
      cnt_nxt                = cnt_r + 1'b1;
      sum_x_nxt[commit_cls]  = sum_x_r[commit_cls] + tcnc_pkg::sum_t'(commit_x);
      sum_y_nxt[commit_cls]  = sum_y_r[commit_cls] + tcnc_pkg::sum_t'(commit_y);
      mcnt_nxt[commit_cls]   = mcnt_r[commit_cls] + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcnc_pkg::S_IDLE;
      cnt_r       <= '0;
      sum_x_r     <= '{default: '0};
      sum_y_r     <= '{default: '0};
      mcnt_r      <= '{default: '0};
      cen_x_r     <= '{default: '0};
      cen_y_r     <= '{default: '0};
      cen_v_r     <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      mcnt_r      <= mcnt_nxt;
      cen_x_r     <= cen_x_nxt;
      cen_y_r     <= cen_y_nxt;
      cen_v_r     <= cen_v_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    sel_r     <= sel_nxt;
    step_r    <= step_nxt;
    dvd_r     <= dvd_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    neg_r     <= neg_nxt;
    cls_r     <= cls_nxt;
    sqx_r     <= sqx_nxt;
    sqy_r     <= sqy_nxt;
    best_r    <= best_nxt;
    win_r     <= win_nxt;
    found_r   <= found_nxt;
    dist_r    <= dist_nxt;
    idx_r     <= idx_nxt;
    s2_cls_r  <= s2_cls_nxt;
    nsqx_r    <= nsqx_nxt;
    nsqy_r    <= nsqy_nxt;
    nn_best_r <= nn_best_nxt;
    nn_has_r  <= nn_has_nxt;
    root_r    <= root_nxt;
    bit_r     <= bit_nxt;
    out_r     <= out_nxt;
  end

  // Checks
  `TCNC_ASSERT(a_cnt_range, cnt_r <= tcnc_pkg::cnt_t'(tcnc_pkg::TABLE_DEPTH), "entry count past depth")
  `TCNC_ASSERT(a_members, (mcnt_r[0] + mcnt_r[1] + mcnt_r[2]) == cnt_r, "class counts disagree with table")
  `TCNC_ASSERT_NEXT(a_busy, start && !busy && in_item.mode != tcnc_pkg::MODE_LOAD, busy && !out_valid, "long item not busy")
  `TCNC_ASSERT(a_out_class, !out_valid || out_item.class_out != tcnc_pkg::LABEL_UNKNOWN, "bad class out")

endmodule

`default_nettype wire
